>>> rtl/core/artnet_dmx_packet_receiver_defines.svh
// ---------------------------------------------------------------------------
// Art-Net DMX receiver assertion macros
// Shared concurrent assertion forms used by the receiver RTL.
// ---------------------------------------------------------------------------
`ifndef ARTNET_DMX_PACKET_RECEIVER_DEFINES_SVH
`define ARTNET_DMX_PACKET_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ADR_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ADR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/core/adr_pkg.sv
// ---------------------------------------------------------------------------
// Art-Net DMX receiver package
// Types and fixed protocol constants shared by the receiver modules.
// ---------------------------------------------------------------------------
package adr_pkg;

  // Result kinds.
  localparam logic [1:0] EV_WRITE  = 2'd0;
  localparam logic [1:0] EV_COMMIT = 2'd1;
  localparam logic [1:0] EV_POLL   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NET      = 2'd0;
  localparam logic [1:0] CFG_SUBNET   = 2'd1;
  localparam logic [1:0] CFG_UNIVERSE = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Protocol constants.
  localparam logic [15:0] OP_OUTPUT        = 16'h5000;
  localparam logic [15:0] OP_POLL          = 16'h2000;
  localparam logic [15:0] VERSION_REQUIRED = 16'd14;
  localparam logic [15:0] ID_LEN           = 16'd8;
  localparam logic [15:0] OFF_OP_LO        = 16'd8;
  localparam logic [15:0] OFF_OP_HI        = 16'd9;
  localparam logic [15:0] OFF_VER_HI       = 16'd10;
  localparam logic [15:0] OFF_VER_LO       = 16'd11;
  localparam logic [15:0] OFF_SUBUNI       = 16'd14;
  localparam logic [15:0] OFF_NET          = 16'd15;
  localparam logic [15:0] OFF_LEN_HI       = 16'd16;
  localparam logic [15:0] OFF_LEN_LO       = 16'd17;
  localparam logic [15:0] DATA_START       = 16'd18;
  localparam logic [16:0] OPHDR_LEN        = 17'd10;
  localparam logic [16:0] POLL_MIN_LEN     = 17'd13;
  localparam logic [15:0] OFFSET_MAX       = 16'hFFFF;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  pixel_byte;
    logic [8:0]  pixel_position;
    logic [15:0] frame_length;
    logic        node_active;
    logic        final_of_run;
  } adr_result_t;

  // Results produced by one byte, in delivery order.
  typedef struct packed {
    logic [1:0]  num;
    adr_result_t first;
    adr_result_t second;
  } adr_push_t;

  typedef struct packed {
    logic                  not_empty;
    logic                  room_for_two;
    logic [FIFO_CNT_W-1:0] count;
  } adr_fifo_stat_t;

  // Bytes of the "Art-Net" identifier followed by a zero byte.
  function automatic logic [7:0] art_id(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h41;
      3'd1:    ch = 8'h72;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h2D;
      3'd4:    ch = 8'h4E;
      3'd5:    ch = 8'h65;
      3'd6:    ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/core/adr_in_if.sv
// ---------------------------------------------------------------------------
// Art-Net DMX receiver input channel
// Valid/ready channel carrying one UDP payload byte per item.
// ---------------------------------------------------------------------------
interface adr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_packet;

  modport source (output valid, output rx_byte, output end_of_packet, input ready);
  modport sink   (input valid, input rx_byte, input end_of_packet, output ready);
endinterface

>>> rtl/core/adr_out_if.sv
// ---------------------------------------------------------------------------
// Art-Net DMX receiver result channel
// Valid/ready channel carrying one receiver event per item.
// ---------------------------------------------------------------------------
interface adr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  pixel_byte;
  logic [8:0]  pixel_position;
  logic [15:0] frame_length;
  logic        node_active;
  logic        final_of_run;

  modport source (output valid, output event_kind, output pixel_byte,
                  output pixel_position, output frame_length, output node_active,
                  output final_of_run, input ready);
  modport sink   (input valid, input event_kind, input pixel_byte,
                  input pixel_position, input frame_length, input node_active,
                  input final_of_run, output ready);
endinterface

>>> rtl/core/adr_result_fifo.sv
// ---------------------------------------------------------------------------
// Art-Net DMX receiver result queue
// Small queue that takes up to two results per cycle and gives one.
// ---------------------------------------------------------------------------
module adr_result_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  adr_pkg::adr_push_t     push,
  input  logic                   pop,
  output adr_pkg::adr_result_t   head,
  output adr_pkg::adr_fifo_stat_t stat
);
  import adr_pkg::*;

  adr_result_t           mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic [FIFO_PTR_W-1:0] wr_ptr_p1;
  logic                  do_pop;

  assign do_pop    = pop && (count_r != '0);
  assign wr_ptr_p1 = wr_ptr_r + FIFO_PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push.num);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(do_pop);
    count_nxt  = count_r + FIFO_CNT_W'(push.num) - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.second;
    end
  end

  assign head              = mem_r[rd_ptr_r];
  assign stat.not_empty    = (count_r != '0);
  assign stat.room_for_two = (count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign stat.count        = count_r;

endmodule

>>> rtl/core/artnet_dmx_packet_receiver.sv
// ---------------------------------------------------------------------------
// Art-Net DMX packet receiver
// Parses ArtDmx and ArtPoll packets one payload byte at a time.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Item                        Handshake
//   in_ch    sink       one payload byte + last     valid/ready
//   out_ch   source     one event (write/commit/poll) valid/ready
//   cfg_*    sink       register write              write enable, no wait
//
// An accepted byte is held in an input register and parsed from there, and its
// results (at most two) are written into a four-entry result queue.
// One byte per clock is sustained while the queue has room for two results;
// the queue drains one result per clock while out_ch is ready.
// Input is stalled only when the queue lacks room for two results.
// Reset (rst_n low, synchronous) clears the parse state, the queue and the
// configuration registers; there is no clearing pass.
//
`include "artnet_dmx_packet_receiver_defines.svh"

module artnet_dmx_packet_receiver #(
  parameter int PAYLOAD_BYTES = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  adr_in_if.sink                        in_ch,
  adr_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [adr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import adr_pkg::*;

  localparam logic [16:0] PayloadLimit = 17'(PAYLOAD_BYTES);

  // Configuration registers.
  logic [6:0] node_net_r;
  logic [3:0] node_subnet_r;
  logic [3:0] node_universe_r;

  // Input register stage.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eop_r;
  logic       s1_fire;
  logic       in_fire;

  // Per-packet parse state.
  logic [15:0] byte_offset_r, byte_offset_nxt;
  logic        header_good_r, header_good_nxt;
  logic [15:0] op_code_r, op_code_nxt;
  logic [15:0] protocol_version_r, protocol_version_nxt;
  logic [7:0]  sub_universe_byte_r, sub_universe_byte_nxt;
  logic        address_match_r, address_match_nxt;
  logic [15:0] declared_length_r, declared_length_nxt;
  logic        seen_packet_r, seen_packet_nxt;

  // State after this byte's field capture, before end-of-packet clearing.
  logic        hg_upd;
  logic [15:0] op_upd;
  logic [15:0] ver_upd;
  logic [7:0]  sub_upd;
  logic        match_upd;
  logic [15:0] len_upd;

  logic        dmx_ok;
  logic [15:0] data_off;
  logic        is_data;
  logic [16:0] total;
  logic [16:0] need_len;
  logic        is_commit;
  logic        is_poll;

  adr_result_t    res_write;
  adr_result_t    res_event;
  adr_push_t      push;
  adr_result_t    head;
  adr_fifo_stat_t fifo_stat;

  // -------------------------------------------------------------------------
  // Configuration writes; indexes beyond the list are ignored.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_net_r      <= '0;
      node_subnet_r   <= '0;
      node_universe_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NET:      node_net_r      <= cfg_wdata;
        CFG_SUBNET:   node_subnet_r   <= cfg_wdata[3:0];
        CFG_UNIVERSE: node_universe_r <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Input register. The parse stage fires only when the queue can take the
  // worst case of two results, so the input register never overflows.
  // -------------------------------------------------------------------------
  assign s1_fire     = s1_valid_r && fifo_stat.room_for_two;
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_ch.rx_byte;
      s1_eop_r  <= in_ch.end_of_packet;
    end
  end

  // -------------------------------------------------------------------------
  // Field capture: each header field is taken at its fixed byte offset.
  // -------------------------------------------------------------------------
  always_comb begin
    hg_upd    = header_good_r;
    op_upd    = op_code_r;
    ver_upd   = protocol_version_r;
    sub_upd   = sub_universe_byte_r;
    match_upd = address_match_r;
    len_upd   = declared_length_r;
    if (byte_offset_r < ID_LEN) begin
      if (s1_byte_r != art_id(byte_offset_r[2:0])) begin
        hg_upd = 1'b0;
      end
    end else if (byte_offset_r == OFF_OP_LO) begin
      op_upd = {op_code_r[15:8], s1_byte_r};
    end else if (byte_offset_r == OFF_OP_HI) begin
      op_upd = {s1_byte_r, op_code_r[7:0]};
    end else if (byte_offset_r == OFF_VER_HI) begin
      ver_upd = {s1_byte_r, protocol_version_r[7:0]};
    end else if (byte_offset_r == OFF_VER_LO) begin
      ver_upd = {protocol_version_r[15:8], s1_byte_r};
    end else if (byte_offset_r == OFF_SUBUNI) begin
      sub_upd = s1_byte_r;
    end else if (byte_offset_r == OFF_NET) begin
      // The whole net byte is compared, so a set top bit never matches.
      match_upd = (s1_byte_r == {1'b0, node_net_r})
                  && (sub_universe_byte_r[7:4] == node_subnet_r)
                  && (sub_universe_byte_r[3:0] == node_universe_r);
    end else if (byte_offset_r == OFF_LEN_HI) begin
      len_upd = {s1_byte_r, declared_length_r[7:0]};
    end else if (byte_offset_r == OFF_LEN_LO) begin
      len_upd = {declared_length_r[15:8], s1_byte_r};
    end
  end

  // -------------------------------------------------------------------------
  // Event decisions for this byte.
  // -------------------------------------------------------------------------
  always_comb begin
    dmx_ok   = hg_upd && (op_upd == OP_OUTPUT) && (ver_upd == VERSION_REQUIRED)
               && match_upd;
    data_off = byte_offset_r - DATA_START;
    is_data  = (byte_offset_r >= DATA_START) && dmx_ok
               && ({1'b0, data_off} < PayloadLimit);
    // A saturated counter makes the total length read as the maximum.
    total    = (byte_offset_r == OFFSET_MAX) ? {1'b0, OFFSET_MAX}
                                             : ({1'b0, byte_offset_r} + 17'd1);
    need_len = {1'b0, DATA_START} + {1'b0, len_upd};
    is_commit = s1_eop_r && (total >= OPHDR_LEN) && hg_upd && (op_upd == OP_OUTPUT)
                && dmx_ok && (total >= {1'b0, DATA_START}) && (total >= need_len);
    is_poll   = s1_eop_r && (total >= OPHDR_LEN) && hg_upd && (op_upd == OP_POLL)
                && (total >= POLL_MIN_LEN);
  end

  // -------------------------------------------------------------------------
  // Result assembly. A data write always comes before a commit on the same
  // byte, and only the last result of the byte carries final_of_run.
  // -------------------------------------------------------------------------
  always_comb begin
    res_write.event_kind     = EV_WRITE;
    res_write.pixel_byte     = s1_byte_r;
    res_write.pixel_position = data_off[8:0];
    res_write.frame_length   = '0;
    res_write.node_active    = seen_packet_nxt;
    res_write.final_of_run   = !(is_commit || is_poll);

    res_event.event_kind     = is_commit ? EV_COMMIT : EV_POLL;
    res_event.pixel_byte     = '0;
    res_event.pixel_position = '0;
    res_event.frame_length   = is_commit ? len_upd : 16'd0;
    res_event.node_active    = seen_packet_nxt;
    res_event.final_of_run   = 1'b1;

    push.first  = is_data ? res_write : res_event;
    push.second = res_event;
    push.num    = '0;
    if (s1_fire) begin
      push.num = 2'(is_data) + 2'(is_commit || is_poll);
    end
  end

  // -------------------------------------------------------------------------
  // Parse state update. The last byte of a packet returns everything but the
  // sticky arrival flag to its reset values; the offset saturates otherwise.
  // -------------------------------------------------------------------------
  always_comb begin
    byte_offset_nxt       = byte_offset_r;
    header_good_nxt       = header_good_r;
    op_code_nxt           = op_code_r;
    protocol_version_nxt  = protocol_version_r;
    sub_universe_byte_nxt = sub_universe_byte_r;
    address_match_nxt     = address_match_r;
    declared_length_nxt   = declared_length_r;
    seen_packet_nxt       = seen_packet_r || s1_valid_r;
    if (s1_fire) begin
      if (s1_eop_r) begin
        byte_offset_nxt       = '0;
        header_good_nxt       = 1'b1;
        op_code_nxt           = '0;
        protocol_version_nxt  = '0;
        sub_universe_byte_nxt = '0;
        address_match_nxt     = 1'b0;
        declared_length_nxt   = '0;
      end else begin
        if (byte_offset_r != OFFSET_MAX) begin
          byte_offset_nxt = byte_offset_r + 16'd1;
        end
        header_good_nxt       = hg_upd;
        op_code_nxt           = op_upd;
        protocol_version_nxt  = ver_upd;
        sub_universe_byte_nxt = sub_upd;
        address_match_nxt     = match_upd;
        declared_length_nxt   = len_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r       <= '0;
      header_good_r       <= 1'b1;
      op_code_r           <= '0;
      protocol_version_r  <= '0;
      sub_universe_byte_r <= '0;
      address_match_r     <= 1'b0;
      declared_length_r   <= '0;
      seen_packet_r       <= 1'b0;
    end else begin
      byte_offset_r       <= byte_offset_nxt;
      header_good_r       <= header_good_nxt;
      op_code_r           <= op_code_nxt;
      protocol_version_r  <= protocol_version_nxt;
      sub_universe_byte_r <= sub_universe_byte_nxt;
      address_match_r     <= address_match_nxt;
      declared_length_r   <= declared_length_nxt;
      seen_packet_r       <= seen_packet_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Result queue and output channel.
  // -------------------------------------------------------------------------
  adr_result_fifo u_result_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_ch.ready),
    .head  (head),
    .stat  (fifo_stat)
  );

  assign out_ch.valid          = fifo_stat.not_empty;
  assign out_ch.event_kind     = head.event_kind;
  assign out_ch.pixel_byte     = head.pixel_byte;
  assign out_ch.pixel_position = head.pixel_position;
  assign out_ch.frame_length   = head.frame_length;
  assign out_ch.node_active    = head.node_active;
  assign out_ch.final_of_run   = head.final_of_run;

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `ADR_ASSERT_SAME(a_fifo_bound, 1'b1, fifo_stat.count <= FIFO_CNT_W'(FIFO_DEPTH),
    "result queue holds more than its depth")
  `ADR_ASSERT_SAME(a_active_on_result, out_ch.valid, out_ch.node_active,
    "result delivered without the arrival flag set")
  `ADR_ASSERT_NEXT(a_clear_on_last, s1_fire && s1_eop_r,
    byte_offset_r == 16'd0 && header_good_r,
    "parse state not cleared after the last byte of a packet")
  `ADR_ASSERT_SAME(a_event_no_byte, out_ch.valid && (out_ch.event_kind != EV_WRITE),
    out_ch.pixel_byte == 8'd0 && out_ch.final_of_run,
    "commit or poll result carries payload or is not final")

endmodule
